/* design/aspq_pkg.sv */
// Package with the shared types, constants and tables of the attitude setpoint block.
`default_nettype none
package aspq_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int CFG_AW = 5;

  localparam logic [14:0] TILT_LIMIT_RST = 15'd5461;
  localparam logic [12:0] YAW_STEP_RST = 13'd328;
  localparam logic [14:0] YAW_RATE_SCALE_RST = 15'd12868;
  localparam logic [15:0] HOVER_THRUST_RST = 16'd10045;
  localparam logic [15:0] THRUST_GAIN_RST = 16'd3072;
  localparam logic [15:0] THRUST_MIN_RST = 16'd5023;
  localparam logic [15:0] THRUST_MAX_RST = 16'd15068;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

  typedef enum logic [2:0] {
    REG_TILT_LIMIT = 3'd0,
    REG_YAW_STEP = 3'd1,
    REG_YAW_RATE_SCALE = 3'd2,
    REG_HOVER_THRUST = 3'd3,
    REG_THRUST_GAIN = 3'd4,
    REG_THRUST_MIN = 3'd5,
    REG_THRUST_MAX = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [14:0] tilt_limit;
    logic [12:0] yaw_step;
    logic [14:0] yaw_rate_scale;
    logic [15:0] hover_thrust;
    logic [15:0] thrust_gain;
    logic [15:0] thrust_min;
    logic [15:0] thrust_max;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_MWB,
    OP_CINIT,
    OP_CITER,
    OP_CFIN,
    OP_QM1,
    OP_QM2,
    OP_QACC,
    OP_QWB,
    OP_OUT
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_MWB,
    S_CINIT,
    S_CITER,
    S_CFIN,
    S_QM1,
    S_QM2,
    S_QACC,
    S_QWB,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t op;
    logic [3:0] step;
    logic [1:0] sel;
    logic term;
  } cmd_t;

  function automatic logic signed [33:0] atan_val(input logic [3:0] i);
    logic signed [33:0] v;
    case (i)
      4'd0: v = 34'sd536870912;
      4'd1: v = 34'sd316933406;
      4'd2: v = 34'sd167458907;
      4'd3: v = 34'sd85004756;
      4'd4: v = 34'sd42667331;
      4'd5: v = 34'sd21354465;
      4'd6: v = 34'sd10679838;
      4'd7: v = 34'sd5340245;
      4'd8: v = 34'sd2670163;
      4'd9: v = 34'sd1335087;
      4'd10: v = 34'sd667544;
      4'd11: v = 34'sd333772;
      4'd12: v = 34'sd166886;
      4'd13: v = 34'sd83443;
      4'd14: v = 34'sd41722;
      4'd15: v = 34'sd20861;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* design/aspq_in_if.sv */
// Input channel interface carrying one action beat.
`default_nettype none
interface aspq_in_if;
  logic valid;
  logic ready;
  logic odom_ready;
  logic signed [15:0] roll_action;
  logic signed [15:0] pitch_action;
  logic signed [15:0] yaw_rate_action;
  logic signed [15:0] thrust_action;

  modport source (output valid, odom_ready, roll_action, pitch_action, yaw_rate_action,
                  thrust_action, input ready);
  modport sink (input valid, odom_ready, roll_action, pitch_action, yaw_rate_action,
                thrust_action, output ready);
endinterface
`default_nettype wire

/* design/aspq_out_if.sv */
// Result channel interface carrying one attitude setpoint beat.
`default_nettype none
interface aspq_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] yaw_rate_out;
  logic [15:0] thrust_out;
  logic [15:0] yaw_out;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, yaw_rate_out, thrust_out,
                  yaw_out, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, yaw_rate_out, thrust_out,
                yaw_out, output ready);
endinterface
`default_nettype wire

/* design/aspq_regs.sv */
// Configuration register file behind the APB-style port.
`default_nettype none
module aspq_regs
  import aspq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic      [31:0]       cfg_prdata,
  output logic                   cfg_pready,
  output cfg_t                   cfg
);

  cfg_t cfg_r;
  logic [2:0] idx;

  assign idx = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tilt_limit <= TILT_LIMIT_RST;
      cfg_r.yaw_step <= YAW_STEP_RST;
      cfg_r.yaw_rate_scale <= YAW_RATE_SCALE_RST;
      cfg_r.hover_thrust <= HOVER_THRUST_RST;
      cfg_r.thrust_gain <= THRUST_GAIN_RST;
      cfg_r.thrust_min <= THRUST_MIN_RST;
      cfg_r.thrust_max <= THRUST_MAX_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (idx)
        REG_TILT_LIMIT: cfg_r.tilt_limit <= cfg_pwdata[14:0];
        REG_YAW_STEP: cfg_r.yaw_step <= cfg_pwdata[12:0];
        REG_YAW_RATE_SCALE: cfg_r.yaw_rate_scale <= cfg_pwdata[14:0];
        REG_HOVER_THRUST: cfg_r.hover_thrust <= cfg_pwdata[15:0];
        REG_THRUST_GAIN: cfg_r.thrust_gain <= cfg_pwdata[15:0];
        REG_THRUST_MIN: cfg_r.thrust_min <= cfg_pwdata[15:0];
        REG_THRUST_MAX: cfg_r.thrust_max <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TILT_LIMIT: cfg_prdata = {17'd0, cfg_r.tilt_limit};
      REG_YAW_STEP: cfg_prdata = {19'd0, cfg_r.yaw_step};
      REG_YAW_RATE_SCALE: cfg_prdata = {17'd0, cfg_r.yaw_rate_scale};
      REG_HOVER_THRUST: cfg_prdata = {16'd0, cfg_r.hover_thrust};
      REG_THRUST_GAIN: cfg_prdata = {16'd0, cfg_r.thrust_gain};
      REG_THRUST_MIN: cfg_prdata = {16'd0, cfg_r.thrust_min};
      REG_THRUST_MAX: cfg_prdata = {16'd0, cfg_r.thrust_max};
      default: cfg_prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

/* design/aspq_ctrl.sv */
// Controller state machine that sequences the datapath for one beat.
`default_nettype none
module aspq_ctrl
  import aspq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_odom,
  output logic      in_ready,
  input  wire logic out_ready,
  output logic      out_valid,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic term_r, term_nxt;
  logic out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= 4'd0;
      sel_r <= 2'd0;
      term_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      sel_r <= sel_nxt;
      term_r <= term_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    sel_nxt = sel_r;
    term_nxt = term_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready = 1'b0;
    cmd.op = OP_NONE;
    cmd.step = step_r;
    cmd.sel = sel_r;
    cmd.term = term_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        step_nxt = 4'd0;
        sel_nxt = 2'd0;
        term_nxt = 1'b0;
        if (in_valid && in_odom) begin
          cmd.op = OP_LOAD;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op = OP_MUL;
        state_nxt = S_MWB;
      end
      S_MWB: begin
        cmd.op = OP_MWB;
        if (step_r == 4'd4) begin
          step_nxt = 4'd0;
          state_nxt = S_CINIT;
        end else begin
          step_nxt = step_r + 4'd1;
          state_nxt = S_MUL;
        end
      end
      S_CINIT: begin
        cmd.op = OP_CINIT;
        step_nxt = 4'd0;
        state_nxt = S_CITER;
      end
      S_CITER: begin
        cmd.op = OP_CITER;
        step_nxt = step_r + 4'd1;
        if (step_r == 4'(CORDIC_STEPS - 1)) begin
          state_nxt = S_CFIN;
        end
      end
      S_CFIN: begin
        cmd.op = OP_CFIN;
        if (sel_r == 2'd2) begin
          sel_nxt = 2'd0;
          term_nxt = 1'b0;
          state_nxt = S_QM1;
        end else begin
          sel_nxt = sel_r + 2'd1;
          state_nxt = S_CINIT;
        end
      end
      S_QM1: begin
        cmd.op = OP_QM1;
        state_nxt = S_QM2;
      end
      S_QM2: begin
        cmd.op = OP_QM2;
        state_nxt = S_QACC;
      end
      S_QACC: begin
        cmd.op = OP_QACC;
        if (term_r) begin
          state_nxt = S_QWB;
        end else begin
          term_nxt = 1'b1;
          state_nxt = S_QM1;
        end
      end
      S_QWB: begin
        cmd.op = OP_QWB;
        term_nxt = 1'b0;
        if (sel_r == 2'd3) begin
          state_nxt = S_DONE;
        end else begin
          sel_nxt = sel_r + 2'd1;
          state_nxt = S_QM1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.op = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* design/aspq_dp.sv */
// Datapath with the shared multiplier, the CORDIC unit and the result registers.
`default_nettype none
module aspq_dp
  import aspq_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  cmd_t                    cmd,
  input  cfg_t                    cfg,
  input  wire logic signed [15:0] roll_action,
  input  wire logic signed [15:0] pitch_action,
  input  wire logic signed [15:0] yaw_rate_action,
  input  wire logic signed [15:0] thrust_action,
  output logic signed [15:0]      quat_w,
  output logic signed [15:0]      quat_x,
  output logic signed [15:0]      quat_y,
  output logic signed [15:0]      quat_z,
  output logic signed [15:0]      yaw_rate_out,
  output logic        [15:0]      thrust_out,
  output logic        [15:0]      yaw_out
);

  localparam int SH = 31 - ANGLE_BITS;

  logic signed [15:0] roll_r, pitch_r, yr_r, th_r;
  logic signed [47:0] mul_r;
  logic signed [19:0] roll_ang_r, pitch_ang_r;
  logic [ANGLE_BITS-1:0] yaw_r;
  logic signed [15:0] rate_r;
  logic [15:0] thrust_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic flip_r;
  logic signed [15:0] cosv_r [3];
  logic signed [15:0] sinv_r [3];
  logic signed [45:0] acc_r;
  logic signed [15:0] q_r [4];
  logic signed [15:0] qw_r, qx_r, qy_r, qz_r, rate_o_r;
  logic [15:0] thrust_o_r, yaw_o_r;

  logic signed [30:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [33:0] r14;
  logic signed [34:0] thr_sum;
  logic signed [31:0] ang32;
  logic signed [31:0] phase;
  logic signed [33:0] z0;
  logic signed [33:0] dx, dy;
  logic signed [33:0] fx, fy, rx, ry;
  logic signed [15:0] f1, f2, f3;
  logic ys, rs;
  logic signed [45:0] triple;
  logic signed [45:0] acc_rnd;
  logic signed [15:0] qv;

  assign quat_w = qw_r;
  assign quat_x = qx_r;
  assign quat_y = qy_r;
  assign quat_z = qz_r;
  assign yaw_rate_out = rate_o_r;
  assign thrust_out = thrust_o_r;
  assign yaw_out = yaw_o_r;

  always_comb begin
    ys = (cmd.sel[1]) ^ cmd.term;
    rs = (cmd.sel == 2'd1 || cmd.sel == 2'd2) ^ cmd.term;
    f1 = ys ? sinv_r[2] : cosv_r[2];
    f2 = cmd.term ? sinv_r[1] : cosv_r[1];
    f3 = rs ? sinv_r[0] : cosv_r[0];
    mul_a = 31'(roll_r);
    mul_b = 17'sd0;
    case (cmd.op)
      OP_MUL: begin
        case (cmd.step)
          4'd0: begin
            mul_a = 31'(roll_r);
            mul_b = $signed({2'b00, cfg.tilt_limit});
          end
          4'd1: begin
            mul_a = 31'(pitch_r);
            mul_b = $signed({2'b00, cfg.tilt_limit});
          end
          4'd2: begin
            mul_a = 31'(yr_r);
            mul_b = $signed({4'b0000, cfg.yaw_step});
          end
          4'd3: begin
            mul_a = 31'(yr_r);
            mul_b = $signed({2'b00, cfg.yaw_rate_scale});
          end
          default: begin
            mul_a = 31'(th_r);
            mul_b = $signed({1'b0, cfg.thrust_gain});
          end
        endcase
      end
      OP_QM1: begin
        mul_a = 31'(f1);
        mul_b = 17'(f2);
      end
      OP_QM2: begin
        mul_a = mul_r[30:0];
        mul_b = 17'(f3);
      end
      default: ;
    endcase
  end

  always_comb begin
    r14 = ($signed(mul_r[33:0]) + 34'sd8192) >>> 14;
    thr_sum = $signed({19'd0, cfg.hover_thrust}) + 35'(r14);
    case (cmd.sel)
      2'd0: ang32 = 32'(roll_ang_r);
      2'd1: ang32 = 32'(pitch_ang_r);
      default: ang32 = 32'($signed(yaw_r));
    endcase
    phase = ang32 <<< SH;
    z0 = 34'(phase);
    dx = cy_r >>> cmd.step;
    dy = cx_r >>> cmd.step;
    fx = flip_r ? -cx_r : cx_r;
    fy = flip_r ? -cy_r : cy_r;
    rx = (fx + 34'sd32768) >>> 16;
    ry = (fy + 34'sd32768) >>> 16;
    triple = 46'($signed(mul_r[44:0]));
    acc_rnd = (acc_r + 46'sd134217728) >>> 28;
    if (acc_rnd > 46'sd16384) begin
      qv = 16'sd16384;
    end else if (acc_rnd < -46'sd16384) begin
      qv = -16'sd16384;
    end else begin
      qv = acc_rnd[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_r <= '0;
    end else if (cmd.op == OP_MWB && cmd.step == 4'd2) begin
      yaw_r <= yaw_r + r14[ANGLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        roll_r <= roll_action;
        pitch_r <= pitch_action;
        yr_r <= yaw_rate_action;
        th_r <= thrust_action;
      end
      OP_MUL, OP_QM1, OP_QM2: mul_r <= mul_a * mul_b;
      OP_MWB: begin
        case (cmd.step)
          4'd0: roll_ang_r <= r14[19:0];
          4'd1: pitch_ang_r <= r14[19:0];
          4'd3: begin
            if (r14 > 34'sd32767) begin
              rate_r <= 16'sd32767;
            end else if (r14 < -34'sd32767) begin
              rate_r <= -16'sd32767;
            end else begin
              rate_r <= r14[15:0];
            end
          end
          4'd4: begin
            if (thr_sum < $signed({19'd0, cfg.thrust_min}) ||
                cfg.thrust_max < cfg.thrust_min) begin
              thrust_r <= cfg.thrust_min;
            end else if (thr_sum > $signed({19'd0, cfg.thrust_max})) begin
              thrust_r <= cfg.thrust_max;
            end else begin
              thrust_r <= thr_sum[15:0];
            end
          end
          default: ;
        endcase
      end
      OP_CINIT: begin
        cx_r <= CORDIC_START;
        cy_r <= 34'sd0;
        if (z0 > 34'sd1073741824) begin
          cz_r <= z0 - 34'sd2147483648;
          flip_r <= 1'b1;
        end else if (z0 < -34'sd1073741824) begin
          cz_r <= z0 + 34'sd2147483648;
          flip_r <= 1'b1;
        end else begin
          cz_r <= z0;
          flip_r <= 1'b0;
        end
      end
      OP_CITER: begin
        if (!cz_r[33]) begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          cz_r <= cz_r - atan_val(cmd.step);
        end else begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          cz_r <= cz_r + atan_val(cmd.step);
        end
      end
      OP_CFIN: begin
        if (cmd.sel != 2'd3) begin
          if (rx > 34'sd16384) begin
            cosv_r[cmd.sel] <= 16'sd16384;
          end else if (rx < -34'sd16384) begin
            cosv_r[cmd.sel] <= -16'sd16384;
          end else begin
            cosv_r[cmd.sel] <= rx[15:0];
          end
          if (ry > 34'sd16384) begin
            sinv_r[cmd.sel] <= 16'sd16384;
          end else if (ry < -34'sd16384) begin
            sinv_r[cmd.sel] <= -16'sd16384;
          end else begin
            sinv_r[cmd.sel] <= ry[15:0];
          end
        end
      end
      OP_QACC: begin
        if (!cmd.term) begin
          acc_r <= triple;
        end else if (cmd.sel[0]) begin
          acc_r <= acc_r - triple;
        end else begin
          acc_r <= acc_r + triple;
        end
      end
      OP_QWB: q_r[cmd.sel] <= qv;
      OP_OUT: begin
        qw_r <= q_r[0];
        qx_r <= q_r[1];
        qy_r <= q_r[2];
        qz_r <= q_r[3];
        rate_o_r <= rate_r;
        thrust_o_r <= thrust_r;
        yaw_o_r <= 16'({yaw_r, 16'd0} >> ANGLE_BITS);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* design/attitude_setpoint_to_quaternion_top.sv */
// Top level of the attitude setpoint to quaternion block.
// The in_ch channel takes one beat of roll, pitch, yaw-rate and thrust actions with a
// ready flag; a beat whose odom_ready is low is taken and dropped with no result.
// A beat with odom_ready high gives one out_ch beat: the attitude quaternion, the
// yaw rate feed-forward, the clamped thrust and the integrated yaw angle.
// Configuration is written through the cfg_ APB-style port; the user must write it
// only while the block is idle, as it does not enforce this. An accepted beat
// runs through scalar products on the shared multiplier, three CORDIC passes and
// quaternion products on the same multiplier, plus the output load. The sequencer
// works on one beat at a time: it takes no new beat until the last result is loaded.
// A finished result sits in the output register while the next beat is accepted and
// computed; if the receiver still stalls when that beat is done, the block waits.
// Reset returns the configuration registers to their defaults, clears the stored
// yaw angle and drops the output valid flag, so the output register reads empty.
`default_nettype none
module attitude_setpoint_to_quaternion_top
  import aspq_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  aspq_in_if.sink                in_ch,
  aspq_out_if.source             out_ch,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic      [31:0]       cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t cfg;
  cmd_t cmd;

  aspq_regs u_regs (
    .clk(clk), .rst_n(rst_n), .cfg_psel(cfg_psel), .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready), .cfg(cfg)
  );

  aspq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_odom(in_ch.odom_ready),
    .in_ready(in_ch.ready), .out_ready(out_ch.ready), .out_valid(out_ch.valid),
    .cmd(cmd)
  );

  aspq_dp #(.ANGLE_BITS(ANGLE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .cfg(cfg),
    .roll_action(in_ch.roll_action), .pitch_action(in_ch.pitch_action),
    .yaw_rate_action(in_ch.yaw_rate_action), .thrust_action(in_ch.thrust_action),
    .quat_w(out_ch.quat_w), .quat_x(out_ch.quat_x), .quat_y(out_ch.quat_y),
    .quat_z(out_ch.quat_z), .yaw_rate_out(out_ch.yaw_rate_out),
    .thrust_out(out_ch.thrust_out), .yaw_out(out_ch.yaw_out)
  );

  a_drop_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !in_ch.odom_ready) |=> in_ch.ready)
    else $error("dropped beat left the block busy");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.odom_ready) |=> !in_ch.ready)
    else $error("block took a beat without starting work");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> !$past(in_ch.ready))
    else $error("result appeared while the block was idle");

endmodule
`default_nettype wire
